[sv/ugli_pkg.sv]
package ugli_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int NEFF_W      = ADDR_W + 1;

  // field widths
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 31;
  localparam int PCNT_W  = 11;
  localparam int IDX_W   = 10;
  localparam int PROD_W  = 2 * DATA_W;

  // stream and register port widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  // divider iteration counter width
  localparam int DIV_CNT_W = $clog2(DATA_W);

  typedef enum logic [1:0] {
    REG_GRID_START  = 2'd0,
    REG_RANGE_END   = 2'd1,
    REG_GRID_STEP   = 2'd2,
    REG_POINT_COUNT = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_IDX,
    ST_INDEX,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_MUL_M,
    ST_MUL_R,
    ST_FRAC_GO,
    ST_DIV_FRAC,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [STEP_W-1:0] rem;
  } div_rsp_t;

endpackage

[sv/uniform_grid_lut_interpolator_unit.sv]
// a table write or an out-of-range query passes through the done state to out_ after acceptance;
// an in-range query first makes two passes through the one radix-2 divider
// (grid index, then fractional term) plus table reads and two uses of the 32x32
// multiplier; one item at a time: the next item is accepted once the result has
// moved to the output register, later still while a finished result waits for out_tready
// rst_n is synchronous, active low: sequencer, handshakes and config registers reset;
// the sample table is not cleared and holds garbage until written
module uniform_grid_lut_interpolator_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // slave side
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index[9:0], entry_value[41:10], query_x[73:42], zero pad [79:74]
  input  logic [ugli_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode (0 write entry, 1 query)
  input  logic                             in_tuser,
  // master side
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_value[31:0]
  output logic [ugli_pkg::OUT_TDATA_W-1:0] out_tdata,
  // in_range
  output logic                             out_tuser,
  // register port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ugli_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ugli_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ugli_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import ugli_pkg::*;

  localparam logic [PROD_W-1:0]      SAT_LIMIT = 64'h0000_0004_0000_0000;
  localparam logic [DATA_W-1:0]      VAL_MAX   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]      VAL_MIN   = 32'h8000_0000;
  localparam logic signed [36:0]     SUM_MAX   = 37'sh00_7FFF_FFFF;
  localparam logic signed [36:0]     SUM_MIN   = 37'sh1F_8000_0000;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] grid_start_r, grid_start_nxt;
  logic [DATA_W-1:0] range_end_r, range_end_nxt;
  logic [STEP_W-1:0] grid_step_r, grid_step_nxt;
  logic [PCNT_W-1:0] point_count_r, point_count_nxt;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    grid_start_nxt  = grid_start_r;
    range_end_nxt   = range_end_r;
    grid_step_nxt   = grid_step_r;
    point_count_nxt = point_count_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_GRID_START:  grid_start_nxt  = cfg_pwdata;
        REG_RANGE_END:   range_end_nxt   = cfg_pwdata;
        REG_GRID_STEP:   grid_step_nxt   = cfg_pwdata[STEP_W-1:0];
        REG_POINT_COUNT: point_count_nxt = cfg_pwdata[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GRID_START:  cfg_prdata = grid_start_r;
      REG_RANGE_END:   cfg_prdata = range_end_r;
      REG_GRID_STEP:   cfg_prdata = CFG_DATA_W'(grid_step_r);
      REG_POINT_COUNT: cfg_prdata = CFG_DATA_W'(point_count_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // zero step runs as one, point count clamps into [2, depth]
  logic [STEP_W-1:0] step_eff;
  logic [NEFF_W-1:0] n_eff;

  assign step_eff = (grid_step_r == '0) ? STEP_W'(1) : grid_step_r;

  always_comb begin
    if (point_count_r < PCNT_W'(2)) begin
      n_eff = NEFF_W'(2);
    end else if (32'(point_count_r) > 32'(TABLE_DEPTH)) begin
      n_eff = NEFF_W'(TABLE_DEPTH);
    end else begin
      n_eff = NEFF_W'(point_count_r);
    end
  end

  // ---------------------------------------------------------------------------
  // input item fields
  // ---------------------------------------------------------------------------
  logic              in_mode;
  logic [IDX_W-1:0]  in_idx;
  logic [DATA_W-1:0] in_value;
  logic [DATA_W-1:0] in_x;
  logic              in_acc;
  logic              x_in_range;
  logic              idx_ok;
  logic [DATA_W-1:0] d_in;

  assign in_mode  = in_tuser;
  assign in_idx   = in_tdata[9:0];
  assign in_value = in_tdata[41:10];
  assign in_x     = in_tdata[73:42];
  assign in_acc   = in_tvalid & in_tready;

  assign x_in_range = ($signed(in_x) >= $signed(grid_start_r)) &&
                      ($signed(in_x) <= $signed(range_end_r));
  assign idx_ok     = 32'(in_idx) < 32'(TABLE_DEPTH);
  // x at or above start, so the wrapped difference is the exact offset
  assign d_in       = in_x - grid_start_r;

  // ---------------------------------------------------------------------------
  // shared units
  // ---------------------------------------------------------------------------
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  ugli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ugli_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ugli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_idx)),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer and datapath registers
  // ---------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] k_r, k_nxt;           // grid index
  logic [STEP_W-1:0] r_r, r_nxt;           // offset past grid point
  logic [ADDR_W-1:0] b_r, b_nxt;           // base entry
  logic [DATA_W-1:0] m_r, m_nxt;           // whole steps past base (extrapolation)
  logic [DATA_W-1:0] y0_r, y0_nxt;
  logic [DATA_W-1:0] adiff_r, adiff_nxt;   // |y1 - y0|
  logic              neg_r, neg_nxt;       // y1 < y0
  logic [PROD_W-1:0] mprod_r, mprod_nxt;   // m * |diff|
  logic              sat_r, sat_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic              remnz_r, remnz_nxt;
  logic [DATA_W-1:0] res_val_r, res_val_nxt;
  logic              res_flag_r, res_flag_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_flag_r, out_flag_nxt;

  // helpers
  logic [DATA_W:0]   diff_w;
  logic [DATA_W-1:0] nm1;
  logic [DATA_W:0]   qinc;
  logic [36:0]       mterm, fterm, sum;

  assign diff_w = {ram_rdata[DATA_W-1], ram_rdata} - {y0_r[DATA_W-1], y0_r};
  assign nm1    = DATA_W'(n_eff) - DATA_W'(1);
  assign qinc   = {1'b0, q_r} + (DATA_W+1)'(remnz_r);

  // not saturated means m * |diff| stays at or below 2^34
  assign mterm = neg_r ? (37'd0 - {2'b00, mprod_r[34:0]}) : {2'b00, mprod_r[34:0]};
  // floor of a negative quotient rounds away from zero on a nonzero remainder
  assign fterm = neg_r ? (37'd0 - {4'b0000, qinc}) : {5'b00000, q_r};
  assign sum   = {{5{y0_r[DATA_W-1]}}, y0_r} + mterm + fterm;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    r_nxt        = r_r;
    b_nxt        = b_r;
    m_nxt        = m_r;
    y0_nxt       = y0_r;
    adiff_nxt    = adiff_r;
    neg_nxt      = neg_r;
    mprod_nxt    = mprod_r;
    sat_nxt      = sat_r;
    q_nxt        = q_r;
    remnz_nxt    = remnz_r;
    res_val_nxt  = res_val_r;
    res_flag_nxt = res_flag_r;
    out_data_nxt = out_data_r;
    out_flag_nxt = out_flag_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    div_req      = '0;
    mul_a        = m_r;
    mul_b        = adiff_r;
    ram_we       = 1'b0;
    ram_raddr    = b_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_mode) begin
            // table write: store entry, answer with zero
            ram_we       = idx_ok;
            res_val_nxt  = '0;
            res_flag_nxt = 1'b0;
            state_nxt    = ST_DONE;
          end else if (x_in_range) begin
            res_flag_nxt    = 1'b1;
            div_req.start   = 1'b1;
            div_req.hi      = '0;
            div_req.lo      = d_in;
            div_req.divisor = step_eff;
            state_nxt       = ST_DIV_IDX;
          end else begin
            res_val_nxt  = '0;
            res_flag_nxt = 1'b0;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_DIV_IDX: begin
        if (div_rsp.done) begin
          k_nxt     = div_rsp.quo;
          r_nxt     = div_rsp.rem;
          state_nxt = ST_INDEX;
        end
      end
      ST_INDEX: begin
        // past the last interval, stay on the last two entries and extrapolate
        if (k_r < nm1) begin
          b_nxt = k_r[ADDR_W-1:0];
          m_nxt = '0;
        end else begin
          b_nxt = ADDR_W'(n_eff - NEFF_W'(2));
          m_nxt = k_r - DATA_W'(n_eff - NEFF_W'(2));
        end
        state_nxt = ST_RD0;
      end
      ST_RD0: begin
        ram_raddr = b_r;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        ram_raddr = ADDR_W'(b_r + ADDR_W'(1));
        y0_nxt    = ram_rdata;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        neg_nxt   = diff_w[DATA_W];
        adiff_nxt = diff_w[DATA_W] ? DATA_W'(~diff_w + 1'b1) : diff_w[DATA_W-1:0];
        state_nxt = ST_MUL_M;
      end
      ST_MUL_M: begin
        mul_a     = m_r;
        mul_b     = adiff_r;
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        mul_a     = DATA_W'(r_r);
        mul_b     = adiff_r;
        mprod_nxt = mul_p;
        sat_nxt   = mul_p > SAT_LIMIT;
        state_nxt = ST_FRAC_GO;
      end
      ST_FRAC_GO: begin
        // r * |diff| is below step * 2^32, so the high word is below the step
        div_req.start   = 1'b1;
        div_req.hi      = mul_p[PROD_W-2:DATA_W];
        div_req.lo      = mul_p[DATA_W-1:0];
        div_req.divisor = step_eff;
        state_nxt       = ST_DIV_FRAC;
      end
      ST_DIV_FRAC: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quo;
          remnz_nxt = div_rsp.rem != '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sat_r) begin
          res_val_nxt = neg_r ? VAL_MIN : VAL_MAX;
        end else if ($signed(sum) > SUM_MAX) begin
          res_val_nxt = VAL_MAX;
        end else if ($signed(sum) < SUM_MIN) begin
          res_val_nxt = VAL_MIN;
        end else begin
          res_val_nxt = sum[DATA_W-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // output register frees up or is empty: hand over the item
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_val_r;
          out_flag_nxt  = res_flag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      grid_start_r  <= '0;
      range_end_r   <= '0;
      grid_step_r   <= STEP_W'(65536);
      point_count_r <= PCNT_W'(2);
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      grid_start_r  <= grid_start_nxt;
      range_end_r   <= range_end_nxt;
      grid_step_r   <= grid_step_nxt;
      point_count_r <= point_count_nxt;
    end
    k_r        <= k_nxt;
    r_r        <= r_nxt;
    b_r        <= b_nxt;
    m_r        <= m_nxt;
    y0_r       <= y0_nxt;
    adiff_r    <= adiff_nxt;
    neg_r      <= neg_nxt;
    mprod_r    <= mprod_nxt;
    sat_r      <= sat_nxt;
    q_r        <= q_nxt;
    remnz_r    <= remnz_nxt;
    res_val_r  <= res_val_nxt;
    res_flag_r <= res_flag_nxt;
    out_data_r <= out_data_nxt;
    out_flag_r <= out_flag_nxt;
  end

endmodule

[sv/ugli_ram.sv]
module ugli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ugli_mul.sv]
module ugli_mul (
  input  logic                          clk,
  input  logic [ugli_pkg::DATA_W-1:0]   a,
  input  logic [ugli_pkg::DATA_W-1:0]   b,
  output logic [ugli_pkg::PROD_W-1:0]   p
);
  import ugli_pkg::*;

  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_nxt;

  // unsigned 32x32, registered product
  assign p_nxt = PROD_W'(a) * PROD_W'(b);
  assign p     = p_r;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

[sv/ugli_div.sv]
module ugli_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ugli_pkg::div_req_t  req,
  output ugli_pkg::div_rsp_t  rsp
);
  import ugli_pkg::*;

  // restoring radix-2 divider, one quotient bit per cycle
  // dividend is {hi, lo} with hi below the divisor, so the quotient fits DATA_W bits
  logic [STEP_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_W:0]      trial;
  logic [STEP_W:0]      diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.hi;
      quo_nxt  = req.lo;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule
